// ----- design/sit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    // Coordinate width. The segment-pair payload struct below is fixed by it, and the
    // derived orientation widths follow from it (CMP_WIDTH also from BAND_WIDTH).
    localparam int COORD_WIDTH = 16;

    // Collinear band register width and its APB register index.
    localparam int BAND_WIDTH = 32;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 3;
    localparam logic REG_COLLINEAR_BAND = 1'b0;

    // Derived widths for the orientation arithmetic.
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int CMP_WIDTH = (CROSS_WIDTH > BAND_WIDTH) ? CROSS_WIDTH : BAND_WIDTH;

    typedef enum logic [2:0] {
        CLS_LEFT    = 3'd0,
        CLS_RIGHT   = 3'd1,
        CLS_BEHIND  = 3'd2,
        CLS_BEYOND  = 3'd3,
        CLS_ORIGIN  = 3'd4,
        CLS_DEST    = 3'd5,
        CLS_BETWEEN = 3'd6
    } seg_class_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] s1_start_x;
        logic signed [COORD_WIDTH-1:0] s1_start_y;
        logic signed [COORD_WIDTH-1:0] s1_end_x;
        logic signed [COORD_WIDTH-1:0] s1_end_y;
        logic signed [COORD_WIDTH-1:0] s2_start_x;
        logic signed [COORD_WIDTH-1:0] s2_start_y;
        logic signed [COORD_WIDTH-1:0] s2_end_x;
        logic signed [COORD_WIDTH-1:0] s2_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic       intersects;
        logic [2:0] s2_start_class;
        logic [2:0] s2_end_class;
        logic [2:0] s1_start_class;
        logic [2:0] s1_end_class;
    } seg_result_t;

endpackage

`default_nettype wire

// ----- design/sit_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sit_classify (
    input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] ax,
    input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] ay,
    input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] bx,
    input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] by,
    input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] cx,
    input  wire logic signed [sit_pkg::COORD_WIDTH-1:0] cy,
    input  wire logic [sit_pkg::BAND_WIDTH-1:0]         band,
    output sit_pkg::seg_class_t                          cls
);
    import sit_pkg::*;

    logic signed [DIFF_WIDTH-1:0]  abx, aby, acx, acy;
    logic signed [PROD_WIDTH-1:0]  prod_ab_ac, prod_ac_ab;
    logic signed [PROD_WIDTH-1:0]  sq_abx, sq_aby, sq_acx, sq_acy;
    logic signed [CROSS_WIDTH-1:0] cross_prod, len_ab, len_ac;
    logic [CROSS_WIDTH-1:0]        mag;
    logic                          is_zero, behind;

    // Edge vectors, one bit wider so that the difference is exact.
    assign abx = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
    assign aby = {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
    assign acx = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
    assign acy = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};

    assign prod_ab_ac = abx * acy;
    assign prod_ac_ab = aby * acx;
    assign cross_prod = CROSS_WIDTH'(prod_ab_ac) - CROSS_WIDTH'(prod_ac_ab);
    assign mag = cross_prod[CROSS_WIDTH-1] ? CROSS_WIDTH'(-cross_prod)
                                           : CROSS_WIDTH'(cross_prod);

    // Small cross products fall inside the tolerance band and count as zero.
    assign is_zero = (cross_prod == '0) || (CMP_WIDTH'(mag) < CMP_WIDTH'(band));

    // Opposite nonzero signs on either axis put the point behind the origin.
    assign behind = ((abx != '0) && (acx != '0) && (abx[DIFF_WIDTH-1] != acx[DIFF_WIDTH-1]))
                 || ((aby != '0) && (acy != '0) && (aby[DIFF_WIDTH-1] != acy[DIFF_WIDTH-1]));

    assign sq_abx = abx * abx;
    assign sq_aby = aby * aby;
    assign sq_acx = acx * acx;
    assign sq_acy = acy * acy;
    assign len_ab = CROSS_WIDTH'(sq_abx) + CROSS_WIDTH'(sq_aby);
    assign len_ac = CROSS_WIDTH'(sq_acx) + CROSS_WIDTH'(sq_acy);

    always_comb
    begin
        if (!is_zero && !cross_prod[CROSS_WIDTH-1])
        begin
            cls = CLS_LEFT;
        end
        else if (!is_zero)
        begin
            cls = CLS_RIGHT;
        end
        else if (behind)
        begin
            cls = CLS_BEHIND;
        end
        else if (len_ac > len_ab)
        begin
            cls = CLS_BEYOND;
        end
        else if ((acx == '0) && (acy == '0))
        begin
            cls = CLS_ORIGIN;
        end
        else if ((cx == bx) && (cy == by))
        begin
            cls = CLS_DEST;
        end
        else
        begin
            cls = CLS_BETWEEN;
        end
    end

endmodule

`default_nettype wire

// ----- design/segment_intersection_test_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      seg_pair_t: two segments, eight coordinates
// result    out        result_valid / result_ready  seg_result_t: hit flag and four classes
// config    in         APB psel/penable/pwrite      collinear_band at byte address 0
//
// One item is taken per cycle while item_ready is high; each result passes
// from the input register, through the four orientation units, into the
// result register, and an item can wait in the input register while the
// result register is full.
// Reset clears the valid flags and sets collinear_band to zero.
// When the result is not taken, the input register still takes one more item;
// only with both registers full does item_ready fall.

module segment_intersection_test_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire sit_pkg::seg_pair_t                  item,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output sit_pkg::seg_result_t                     result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sit_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [sit_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [sit_pkg::APB_DATA_WIDTH-1:0]       prdata,
    output logic                                     pready
);
    import sit_pkg::*;

    logic [BAND_WIDTH-1:0] band_reg;
    logic                  stage_valid_reg;
    seg_pair_t             stage_item_reg;
    logic                  result_valid_reg;
    seg_result_t           result_reg;
    seg_result_t           result_next;
    logic                  advance;
    seg_class_t            cls_s2_start, cls_s2_end, cls_s1_start, cls_s1_end;
    logic                  any_touch, any_off, straddle;

    // The APB port has one register; the index is the word address bit.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_COLLINEAR_BAND: band_reg <= pwdata;
                default:            band_reg <= band_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_COLLINEAR_BAND: prdata = band_reg;
            default:            prdata = '0;
        endcase
    end

    // The result register drains when empty or when the consumer takes it,
    // and the input register refills in the same cycle.
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
        if (stage_valid_reg && advance)
        begin
            result_reg <= result_next;
        end
    end

    // Each endpoint of one segment is classified against the other segment.
    sit_classify u_cls_s2_start (
        .ax   (stage_item_reg.s1_start_x),
        .ay   (stage_item_reg.s1_start_y),
        .bx   (stage_item_reg.s1_end_x),
        .by   (stage_item_reg.s1_end_y),
        .cx   (stage_item_reg.s2_start_x),
        .cy   (stage_item_reg.s2_start_y),
        .band (band_reg),
        .cls  (cls_s2_start)
    );

    sit_classify u_cls_s2_end (
        .ax   (stage_item_reg.s1_start_x),
        .ay   (stage_item_reg.s1_start_y),
        .bx   (stage_item_reg.s1_end_x),
        .by   (stage_item_reg.s1_end_y),
        .cx   (stage_item_reg.s2_end_x),
        .cy   (stage_item_reg.s2_end_y),
        .band (band_reg),
        .cls  (cls_s2_end)
    );

    sit_classify u_cls_s1_start (
        .ax   (stage_item_reg.s2_start_x),
        .ay   (stage_item_reg.s2_start_y),
        .bx   (stage_item_reg.s2_end_x),
        .by   (stage_item_reg.s2_end_y),
        .cx   (stage_item_reg.s1_start_x),
        .cy   (stage_item_reg.s1_start_y),
        .band (band_reg),
        .cls  (cls_s1_start)
    );

    sit_classify u_cls_s1_end (
        .ax   (stage_item_reg.s2_start_x),
        .ay   (stage_item_reg.s2_start_y),
        .bx   (stage_item_reg.s2_end_x),
        .by   (stage_item_reg.s2_end_y),
        .cx   (stage_item_reg.s1_end_x),
        .cy   (stage_item_reg.s1_end_y),
        .band (band_reg),
        .cls  (cls_s1_end)
    );

    // Any endpoint lying on the other segment is a hit. Otherwise a collinear
    // endpoint off the segment rules out a crossing, and failing that the
    // segments cross when both pairs of endpoints straddle.
    always_comb
    begin
        any_touch = (cls_s2_start inside {CLS_ORIGIN, CLS_DEST, CLS_BETWEEN})
                 || (cls_s2_end   inside {CLS_ORIGIN, CLS_DEST, CLS_BETWEEN})
                 || (cls_s1_start inside {CLS_ORIGIN, CLS_DEST, CLS_BETWEEN})
                 || (cls_s1_end   inside {CLS_ORIGIN, CLS_DEST, CLS_BETWEEN});
        any_off   = (cls_s2_start inside {CLS_BEHIND, CLS_BEYOND})
                 || (cls_s2_end   inside {CLS_BEHIND, CLS_BEYOND})
                 || (cls_s1_start inside {CLS_BEHIND, CLS_BEYOND})
                 || (cls_s1_end   inside {CLS_BEHIND, CLS_BEYOND});
        straddle  = ((cls_s2_start == CLS_LEFT) != (cls_s2_end == CLS_LEFT))
                 && ((cls_s1_start == CLS_LEFT) != (cls_s1_end == CLS_LEFT));

        result_next.intersects     = any_touch || (!any_off && straddle);
        result_next.s2_start_class = cls_s2_start;
        result_next.s2_end_class   = cls_s2_end;
        result_next.s1_start_class = cls_s1_start;
        result_next.s1_end_class   = cls_s1_end;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The input side stalls only when both registers hold items and the
    // result is not being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (stage_valid_reg && result_valid_reg && !result_ready))
        else $error("item_ready low with a free register");

    // An accepted item always reaches the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> stage_valid_reg)
        else $error("accepted item lost from the input register");

    // A held item in the input register moves to the result register once
    // the result side drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && advance) |=> result_valid_reg)
        else $error("item not moved to the result register");

    // A hit with no touching endpoint needs the second segment's ends on
    // opposite sides of the first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.intersects
            && (result_reg.s2_start_class == CLS_LEFT || result_reg.s2_start_class == CLS_RIGHT)
            && (result_reg.s2_end_class == CLS_LEFT || result_reg.s2_end_class == CLS_RIGHT)
            && (result_reg.s1_start_class == CLS_LEFT || result_reg.s1_start_class == CLS_RIGHT)
            && (result_reg.s1_end_class == CLS_LEFT || result_reg.s1_end_class == CLS_RIGHT))
        |-> (result_reg.s2_start_class != result_reg.s2_end_class))
        else $error("crossing reported without a straddle");

endmodule

`default_nettype wire
